FILE: rtl/core/lcd_window_fill_sequencer_defines.svh
// Assertion macros used by the window fill sequencer top level
`ifndef LCD_WINDOW_FILL_SEQUENCER_DEFINES_SVH
`define LCD_WINDOW_FILL_SEQUENCER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define LWFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LWFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lwfs_pkg.sv
// Types, codes and colour expansion helpers for the window fill sequencer
package lwfs_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RECT  = 2'd1,
        OP_PIXEL = 2'd2,
        OP_FILL  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_CMD_COL,
        SEQ_XS_HI,
        SEQ_XS_LO,
        SEQ_XE_HI,
        SEQ_XE_LO,
        SEQ_CMD_ROW,
        SEQ_YS_HI,
        SEQ_YS_LO,
        SEQ_YE_HI,
        SEQ_YE_LO,
        SEQ_CMD_WR,
        SEQ_PIXEL
    } seq_t;

    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    localparam int unsigned DIM_W = 10;   // screen size and clipped extents
    localparam int unsigned POS_W = 16;

    typedef struct packed {
        logic             start;   // request is on screen and may begin
        logic [POS_W-1:0] xs;
        logic [POS_W-1:0] xe;
        logic [POS_W-1:0] ys;
        logic [POS_W-1:0] ye;
        logic [DIM_W-1:0] cnt_w;
        logic [DIM_W-1:0] cnt_h;
        logic [23:0]      rgb;
    } req_t;

    // c*255/31 = 8c + floor(7c/31); the fraction term counted by thresholds
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [2:0] f;
        f = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
          + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
        return {c, 3'b000} + {5'b0, f};
    endfunction

    // c*255/63 = 4c + floor(c/21)
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [1:0] f;
        f = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
        return {c, 2'b00} + {6'b0, f};
    endfunction

endpackage

FILE: rtl/core/lwfs_req_decode.sv
// Draw request decode: off-screen check, clipping, window bounds, colour expansion
module lwfs_req_decode (
    input  lwfs_pkg::op_t                      op,
    input  logic [lwfs_pkg::POS_W-1:0]         pos_x,
    input  logic [lwfs_pkg::POS_W-1:0]         pos_y,
    input  logic [lwfs_pkg::POS_W-1:0]         rect_width,
    input  logic [lwfs_pkg::POS_W-1:0]         rect_height,
    input  logic [15:0]                        colour,
    input  logic [lwfs_pkg::DIM_W-1:0]         scr_w,
    input  logic [lwfs_pkg::DIM_W-1:0]         scr_h,
    output lwfs_pkg::req_t                     req
);

    logic                          on_screen;
    logic [lwfs_pkg::POS_W:0]      sum_x;
    logic [lwfs_pkg::POS_W:0]      sum_y;
    logic [lwfs_pkg::DIM_W-1:0]    w_clip;
    logic [lwfs_pkg::DIM_W-1:0]    h_clip;
    logic [23:0]                   rgb;

    assign on_screen = (pos_x < lwfs_pkg::POS_W'(scr_w)) && (pos_y < lwfs_pkg::POS_W'(scr_h));

    // x + w > W is the same test as x + w - 1 >= W with zero width never clipping
    assign sum_x  = {1'b0, pos_x} + {1'b0, rect_width};
    assign sum_y  = {1'b0, pos_y} + {1'b0, rect_height};
    assign w_clip = (sum_x > (lwfs_pkg::POS_W + 1)'(scr_w))
                  ? scr_w - pos_x[lwfs_pkg::DIM_W-1:0] : rect_width[lwfs_pkg::DIM_W-1:0];
    assign h_clip = (sum_y > (lwfs_pkg::POS_W + 1)'(scr_h))
                  ? scr_h - pos_y[lwfs_pkg::DIM_W-1:0] : rect_height[lwfs_pkg::DIM_W-1:0];

    assign rgb = {lwfs_pkg::expand5(colour[15:11]),
                  lwfs_pkg::expand6(colour[10:5]),
                  lwfs_pkg::expand5(colour[4:0])};

    always_comb begin
        req       = '0;
        req.rgb   = rgb;
        unique case (op)
            lwfs_pkg::OP_TICK: begin
                req.start = 1'b0;
            end
            lwfs_pkg::OP_RECT: begin
                req.start = on_screen;
                req.xs    = pos_x;
                req.ys    = pos_y;
                req.xe    = pos_x + lwfs_pkg::POS_W'(w_clip) - 16'd1;
                req.ye    = pos_y + lwfs_pkg::POS_W'(h_clip) - 16'd1;
                req.cnt_w = w_clip;
                req.cnt_h = h_clip;
            end
            lwfs_pkg::OP_PIXEL: begin
                req.start = on_screen;
                req.xs    = pos_x;
                req.ys    = pos_y;
                req.xe    = pos_x + 16'd1;
                req.ye    = pos_y + 16'd1;
                req.cnt_w = lwfs_pkg::DIM_W'(1);
                req.cnt_h = lwfs_pkg::DIM_W'(1);
            end
            lwfs_pkg::OP_FILL: begin
                req.start = 1'b1;
                req.xs    = '0;
                req.ys    = '0;
                req.xe    = lwfs_pkg::POS_W'(scr_w) - 16'd1;
                req.ye    = lwfs_pkg::POS_W'(scr_h) - 16'd1;
                req.cnt_w = scr_w;
                req.cnt_h = scr_h;
            end
            default: begin
                req.start = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/lcd_window_fill_sequencer.sv
// Top level: LCD window fill sequencer, request decode plus byte stream generator
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  request or tick beat (op in tuser)
//  m_*       out  m_tvalid/m_tready  one display byte per tick beat
//  apb       in   psel/penable       screen_width @0x0, screen_height @0x4
//
// One beat is taken per cycle while the output does not stall: input register,
// then decode and sequencing into the output register, which holds a tick beat's byte.
// The pixel count product is registered after the extents and load_reg at request start.
// Synchronous active-low reset: idle, screen size 480 x 320.
// Stalls on m_tready back up through the input register to s_tready.
`include "lcd_window_fill_sequencer_defines.svh"

module lcd_window_fill_sequencer #(
    parameter int unsigned COUNT_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // pos_x[15:0] pos_y[31:16] rect_width[47:32]
                                   // rect_height[63:48] colour[79:64]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // byte_value[7:0] byte_valid[8] zero[15:9]
    output logic        m_tuser,   // is_data[0]
    output logic        m_tlast,   // last_byte
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned PROD_W = 2 * lwfs_pkg::DIM_W;
    localparam int unsigned EXT_W  = (COUNT_BITS > PROD_W) ? COUNT_BITS : PROD_W;
    localparam logic [EXT_W-1:0] CNT_MAX = EXT_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [2:0] ADDR_WIDTH_REG  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT_REG = 3'd4;

    // configuration
    logic [lwfs_pkg::DIM_W-1:0] scr_w_reg;
    logic [lwfs_pkg::DIM_W-1:0] scr_h_reg;
    logic                       cfg_wr;

    // input register
    logic                       in_valid_reg;
    logic [79:0]                in_data_reg;
    logic [1:0]                 in_op_reg;
    logic                       fire;
    logic                       tick;
    lwfs_pkg::op_t              in_op;
    lwfs_pkg::req_t             req;

    // sequencer state
    lwfs_pkg::seq_t             state_reg, state_next;
    logic [1:0]                 comp_reg, comp_next;
    logic [COUNT_BITS-1:0]      pix_reg, pix_next;
    logic [lwfs_pkg::POS_W-1:0] xs_reg, xe_reg, ys_reg, ye_reg;
    logic [23:0]                rgb_reg;
    logic [lwfs_pkg::DIM_W-1:0] cnt_w_reg, cnt_h_reg;
    logic                       load_reg;
    logic [PROD_W-1:0]          prod;
    logic [EXT_W-1:0]           prod_ext;
    logic                       begin_req;

    // output beat
    logic [7:0]                 byte_val;
    logic                       byte_data;
    logic                       byte_last;
    logic                       m_valid_reg;
    logic [7:0]                 m_byte_reg;
    logic                       m_bvalid_reg;
    logic                       m_data_reg;
    logic                       m_last_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= lwfs_pkg::DIM_W'(480);
            scr_h_reg <= lwfs_pkg::DIM_W'(320);
        end else if (cfg_wr) begin
            if (paddr[2] == ADDR_WIDTH_REG[2]) begin
                scr_w_reg <= pwdata[lwfs_pkg::DIM_W-1:0];
            end else begin
                scr_h_reg <= pwdata[lwfs_pkg::DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == ADDR_HEIGHT_REG[2]) ? 32'(scr_h_reg) : 32'(scr_w_reg);

    // ---------------- input register ----------------
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_op    = lwfs_pkg::op_t'(in_op_reg);
    assign tick     = (in_op == lwfs_pkg::OP_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
    end

    lwfs_req_decode u_decode (
        .op          (in_op),
        .pos_x       (in_data_reg[15:0]),
        .pos_y       (in_data_reg[31:16]),
        .rect_width  (in_data_reg[47:32]),
        .rect_height (in_data_reg[63:48]),
        .colour      (in_data_reg[79:64]),
        .scr_w       (scr_w_reg),
        .scr_h       (scr_h_reg),
        .req         (req)
    );

    // a request while a sequence runs is dropped
    assign begin_req = fire && !tick && req.start && (state_reg == lwfs_pkg::SEQ_IDLE);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        pix_next   = pix_reg;
        if (load_reg) begin
            pix_next = COUNT_BITS'((prod_ext > CNT_MAX) ? CNT_MAX : prod_ext);
        end
        if (begin_req) begin
            state_next = lwfs_pkg::SEQ_CMD_COL;
            comp_next  = '0;
        end else if (fire && tick) begin
            unique case (state_reg)
                lwfs_pkg::SEQ_IDLE:    state_next = lwfs_pkg::SEQ_IDLE;
                lwfs_pkg::SEQ_CMD_COL: state_next = lwfs_pkg::SEQ_XS_HI;
                lwfs_pkg::SEQ_XS_HI:   state_next = lwfs_pkg::SEQ_XS_LO;
                lwfs_pkg::SEQ_XS_LO:   state_next = lwfs_pkg::SEQ_XE_HI;
                lwfs_pkg::SEQ_XE_HI:   state_next = lwfs_pkg::SEQ_XE_LO;
                lwfs_pkg::SEQ_XE_LO:   state_next = lwfs_pkg::SEQ_CMD_ROW;
                lwfs_pkg::SEQ_CMD_ROW: state_next = lwfs_pkg::SEQ_YS_HI;
                lwfs_pkg::SEQ_YS_HI:   state_next = lwfs_pkg::SEQ_YS_LO;
                lwfs_pkg::SEQ_YS_LO:   state_next = lwfs_pkg::SEQ_YE_HI;
                lwfs_pkg::SEQ_YE_HI:   state_next = lwfs_pkg::SEQ_YE_LO;
                lwfs_pkg::SEQ_YE_LO:   state_next = lwfs_pkg::SEQ_CMD_WR;
                lwfs_pkg::SEQ_CMD_WR: begin
                    comp_next  = '0;
                    state_next = (pix_reg == '0) ? lwfs_pkg::SEQ_IDLE : lwfs_pkg::SEQ_PIXEL;
                end
                lwfs_pkg::SEQ_PIXEL: begin
                    if (comp_reg == 2'd2) begin
                        comp_next = '0;
                        pix_next  = pix_reg - COUNT_BITS'(1);
                        if (pix_reg == COUNT_BITS'(1)) begin
                            state_next = lwfs_pkg::SEQ_IDLE;
                        end
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
                default: state_next = lwfs_pkg::SEQ_IDLE;
            endcase
        end
    end

    // ---------------- sequencer: byte out ----------------
    always_comb begin
        byte_val  = '0;
        byte_data = 1'b1;
        byte_last = 1'b0;
        unique case (state_reg)
            lwfs_pkg::SEQ_IDLE:    byte_data = 1'b0;
            lwfs_pkg::SEQ_CMD_COL: begin
                byte_val  = lwfs_pkg::CMD_COLUMN;
                byte_data = 1'b0;
            end
            lwfs_pkg::SEQ_XS_HI:   byte_val = xs_reg[15:8];
            lwfs_pkg::SEQ_XS_LO:   byte_val = xs_reg[7:0];
            lwfs_pkg::SEQ_XE_HI:   byte_val = xe_reg[15:8];
            lwfs_pkg::SEQ_XE_LO:   byte_val = xe_reg[7:0];
            lwfs_pkg::SEQ_CMD_ROW: begin
                byte_val  = lwfs_pkg::CMD_ROW;
                byte_data = 1'b0;
            end
            lwfs_pkg::SEQ_YS_HI:   byte_val = ys_reg[15:8];
            lwfs_pkg::SEQ_YS_LO:   byte_val = ys_reg[7:0];
            lwfs_pkg::SEQ_YE_HI:   byte_val = ye_reg[15:8];
            lwfs_pkg::SEQ_YE_LO:   byte_val = ye_reg[7:0];
            lwfs_pkg::SEQ_CMD_WR: begin
                byte_val  = lwfs_pkg::CMD_WRITE;
                byte_data = 1'b0;
                byte_last = (pix_reg == '0);
            end
            lwfs_pkg::SEQ_PIXEL: begin
                unique case (comp_reg)
                    2'd0:    byte_val = rgb_reg[23:16];
                    2'd1:    byte_val = rgb_reg[15:8];
                    2'd2:    byte_val = rgb_reg[7:0];
                    default: byte_val = '0;
                endcase
                byte_last = (comp_reg == 2'd2) && (pix_reg == COUNT_BITS'(1));
            end
            default: byte_data = 1'b0;
        endcase
    end

    // ---------------- sequencer registers ----------------
    assign prod     = cnt_w_reg * cnt_h_reg;
    assign prod_ext = EXT_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lwfs_pkg::SEQ_IDLE;
            comp_reg  <= '0;
            pix_reg   <= '0;
            load_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            pix_reg   <= pix_next;
            load_reg  <= begin_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (begin_req) begin
            xs_reg    <= req.xs;
            xe_reg    <= req.xe;
            ys_reg    <= req.ys;
            ye_reg    <= req.ye;
            rgb_reg   <= req.rgb;
            cnt_w_reg <= req.cnt_w;
            cnt_h_reg <= req.cnt_h;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && tick) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && tick) begin
            m_byte_reg   <= byte_val;
            m_bvalid_reg <= (state_reg != lwfs_pkg::SEQ_IDLE);
            m_data_reg   <= byte_data;
            m_last_reg   <= byte_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_bvalid_reg, m_byte_reg};
    assign m_tuser  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- checks ----------------
    `LWFS_ASSERT_NEXT(a_idle_tick_blank, fire && tick && state_reg == lwfs_pkg::SEQ_IDLE,
        m_valid_reg && !m_bvalid_reg && !m_data_reg && !m_last_reg && m_byte_reg == 8'd0,
        "idle tick did not give a blank beat")
    `LWFS_ASSERT_IMPL(a_pixel_count_live, state_reg == lwfs_pkg::SEQ_PIXEL, pix_reg != '0,
        "pixel phase with no pixels left")
    `LWFS_ASSERT_IMPL(a_comp_range, 1'b1, comp_reg != 2'd3, "colour component index out of range")
    `LWFS_ASSERT_IMPL(a_load_at_start, load_reg, state_reg == lwfs_pkg::SEQ_CMD_COL,
        "pixel count loaded outside the first header beat")

endmodule
